>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the heap sort engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge while rst_ni is high.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/hse_pkg.sv
// Package of the heap sort engine: sizes and the result tag type.
// No dependencies; imported by every module of the engine.
package hse_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned ValW        = 32;

  // Side information that travels with each result transfer.
  typedef struct packed {
    logic last;
    logic ovf;
  } hse_tag_t;

endpackage

>>> hw/rtl/hse_store.sv
// Element store of the heap sort engine: one write port and one read port,
// read data registered. Depends on hse_pkg.
module hse_store import hse_pkg::*; #(
  parameter int unsigned Depth = MaxItemsDef,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic signed [ValW-1:0] wr_data_i,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic signed [ValW-1:0] rd_data_o
);

  logic signed [ValW-1:0] mem_q [Depth];
  logic signed [ValW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/hse_seq.sv
// Sequencer of the heap sort engine: collects a set into the store, runs the
// heap build and sort-down passes as read/compare/write steps, then reads the
// sorted set out. Depends on hse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hse_seq import hse_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDef,
  localparam int unsigned AW      = $clog2(MaxItems),
  localparam int unsigned CW      = $clog2(MaxItems + 1),
  localparam int unsigned XW      = AW + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [ValW-1:0] in_value_i,
  input  logic                   in_last_i,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic signed [ValW-1:0] wr_data_o,
  output logic                   rd_en_o,
  output logic [AW-1:0]          rd_addr_o,
  input  logic signed [ValW-1:0] rd_data_i,
  output logic                   issue_o,
  output hse_tag_t               tag_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StSetup = 4'd1;
  localparam logic [3:0] StBRd   = 4'd2;
  localparam logic [3:0] StLoadN = 4'd3;
  localparam logic [3:0] StRdL   = 4'd4;
  localparam logic [3:0] StRdR   = 4'd5;
  localparam logic [3:0] StCmp   = 4'd6;
  localparam logic [3:0] StEnd   = 4'd7;
  localparam logic [3:0] StXRd0  = 4'd8;
  localparam logic [3:0] StXRdK  = 4'd9;
  localparam logic [3:0] StXSwap = 4'd10;
  localparam logic [3:0] StOut   = 4'd11;

  logic [3:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   drop_q, drop_d;
  logic [CW-1:0]          size_q, size_d;
  logic [CW-1:0]          k_q, k_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   build_q, build_d;
  logic [AW-1:0]          node_q, node_d;
  logic signed [ValW-1:0] nval_q, nval_d;
  logic signed [ValW-1:0] lval_q, lval_d;
  logic signed [ValW-1:0] tmp_q, tmp_d;
  logic                   rvalid_q, rvalid_d;

  logic [XW-1:0]          lc, rc, size_x, cidx;
  logic signed [ValW-1:0] cval;
  logic [CW-1:0]          k_m1;

  // Child indices of the current node, wide enough to exceed the store.
  assign lc     = {1'b0, node_q, 1'b1};
  assign rc     = lc + XW'(1);
  assign size_x = XW'(size_q);
  assign k_m1   = k_q - CW'(1);

  // Larger child of those that were read; the left child wins a tie.
  always_comb begin
    if (rvalid_q && (rd_data_i > lval_q)) begin
      cval = rd_data_i;
      cidx = rc;
    end else begin
      cval = lval_q;
      cidx = lc;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drop_d    = drop_q;
    size_d    = size_q;
    k_d       = k_q;
    idx_d     = idx_q;
    build_d   = build_q;
    node_d    = node_q;
    nval_d    = nval_q;
    lval_d    = lval_q;
    tmp_d     = tmp_q;
    rvalid_d  = rvalid_q;
    wr_en_o   = 1'b0;
    wr_addr_o = node_q;
    wr_data_o = nval_q;
    rd_en_o   = 1'b0;
    rd_addr_o = lc[AW-1:0];
    issue_o   = 1'b0;
    tag_o     = '{last: (idx_q + CW'(1)) == count_q, ovf: drop_q};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (count_q < CW'(MaxItems)) begin
            wr_en_o   = 1'b1;
            wr_addr_o = count_q[AW-1:0];
            wr_data_o = in_value_i;
            count_d   = count_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_last_i) begin
            state_d = StSetup;
          end
        end
      end
      StSetup: begin
        size_d = count_q;
        idx_d  = '0;
        if (count_q <= CW'(1)) begin
          state_d = StOut;
        end else begin
          k_d     = count_q >> 1;
          build_d = 1'b1;
          state_d = StBRd;
        end
      end
      StBRd: begin
        rd_en_o   = 1'b1;
        rd_addr_o = k_m1[AW-1:0];
        node_d    = k_m1[AW-1:0];
        state_d   = StLoadN;
      end
      StLoadN: begin
        nval_d  = rd_data_i;
        state_d = StRdL;
      end
      StRdL: begin
        if (lc < size_x) begin
          rd_en_o   = 1'b1;
          rd_addr_o = lc[AW-1:0];
          state_d   = StRdR;
        end else begin
          state_d = StEnd;
        end
      end
      StRdR: begin
        lval_d   = rd_data_i;
        rvalid_d = rc < size_x;
        if (rc < size_x) begin
          rd_en_o   = 1'b1;
          rd_addr_o = rc[AW-1:0];
        end
        state_d = StCmp;
      end
      StCmp: begin
        // The node value is carried in a register; the larger child moves up
        // into the hole and the node value lands where the descent stops.
        if (cval > nval_q) begin
          wr_en_o   = 1'b1;
          wr_addr_o = node_q;
          wr_data_o = cval;
          node_d    = cidx[AW-1:0];
          state_d   = StRdL;
        end else begin
          state_d = StEnd;
        end
      end
      StEnd: begin
        wr_en_o   = 1'b1;
        wr_addr_o = node_q;
        wr_data_o = nval_q;
        if (build_q) begin
          if (k_q == CW'(1)) begin
            build_d = 1'b0;
            k_d     = count_q - CW'(1);
            state_d = StXRd0;
          end else begin
            k_d     = k_m1;
            state_d = StBRd;
          end
        end else if (k_q == CW'(1)) begin
          idx_d   = '0;
          state_d = StOut;
        end else begin
          k_d     = k_m1;
          state_d = StXRd0;
        end
      end
      StXRd0: begin
        rd_en_o   = 1'b1;
        rd_addr_o = '0;
        state_d   = StXRdK;
      end
      StXRdK: begin
        tmp_d     = rd_data_i;
        rd_en_o   = 1'b1;
        rd_addr_o = k_q[AW-1:0];
        state_d   = StXSwap;
      end
      StXSwap: begin
        // The root goes to the end of the heap; the old end value sifts down.
        nval_d    = rd_data_i;
        wr_en_o   = 1'b1;
        wr_addr_o = k_q[AW-1:0];
        wr_data_o = tmp_q;
        node_d    = '0;
        size_d    = k_q;
        state_d   = StRdL;
      end
      StOut: begin
        rd_en_o   = 1'b1;
        rd_addr_o = idx_q[AW-1:0];
        issue_o   = 1'b1;
        idx_d     = idx_q + CW'(1);
        if (tag_o.last) begin
          count_d = '0;
          drop_d  = 1'b0;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      drop_q  <= 1'b0;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      build_q <= build_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q   <= size_d;
    k_q      <= k_d;
    idx_q    <= idx_d;
    node_q   <= node_d;
    nval_q   <= nval_d;
    lval_q   <= lval_d;
    tmp_q    <= tmp_d;
    rvalid_q <= rvalid_d;
  end

  `ASSERT_RST(a_count_bound, count_q <= CW'(MaxItems), "element count above capacity")
  `ASSERT_RST(a_node_in_heap, (state_q == StRdL) |-> (CW'(node_q) < size_q), "node outside heap")
  `ASSERT_RST(a_no_rw_clash, !(wr_en_o && rd_en_o && (wr_addr_o == rd_addr_o)), "read and write hit one entry")

endmodule

>>> hw/rtl/heap_sort_engine.sv
// Top level of the heap sort engine: sequencer, element store and result
// registers. Depends on hse_pkg, hse_seq, hse_store and assert_macros.svh.
//
// Values are taken one per transfer (start high while busy is low) into a
// store of MaxItems entries; values beyond capacity are dropped and flagged
// on overflow_o. The transfer with in_last_i high starts an in-place
// heapsort: about N/2 build sifts and N-1 sort sifts, each descending the
// heap one level per pass through the left read, right read and compare
// states (StRdL, StRdR, StCmp) and ending with a write of the sifted value,
// all through the single read port of the store. The N results then follow
// on consecutive cycles, each marked by out_valid_o for one cycle, ascending,
// with out_last_o on the final one.
// The receiver cannot stall the results. busy falls once the last read has
// issued, so a new set may start while the final result is still leaving.
`include "assert_macros.svh"

module heap_sort_engine import hse_pkg::*; #(
  parameter int unsigned MaxItems = MaxItemsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [ValW-1:0] in_value_i,
  input  logic                   in_last_i,
  output logic                   out_valid_o,
  output logic signed [ValW-1:0] out_value_o,
  output logic                   out_last_o,
  output logic                   overflow_o
);

  localparam int unsigned AW = $clog2(MaxItems);

  logic                   wr_en, rd_en, issue;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic signed [ValW-1:0] wr_data, rd_data;
  hse_tag_t               tag, tag_q;
  logic                   out_valid_q;

  hse_seq #(.MaxItems(MaxItems)) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_value_i (in_value_i),
    .in_last_i  (in_last_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .issue_o    (issue),
    .tag_o      (tag)
  );

  hse_store #(.Depth(MaxItems)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The tag is delayed to line up with the registered read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = rd_data;
  assign out_last_o  = tag_q.last;
  assign overflow_o  = tag_q.ovf;

  `ASSERT_RST(a_last_ends_set, (out_valid_o && out_last_o) |=> !out_valid_o, "result after end of set")

endmodule
